// ----- hdl/sdef_pkg.sv -----
// ----------------------------------------------------------------------------
// sdef_pkg: shared types and constants for the directional Sobel filter
// Controller/datapath command and status structs, register indexes.
// ----------------------------------------------------------------------------
`default_nettype none
package sdef_pkg;
  localparam int unsigned PixW   = 8;
  localparam int unsigned CoordW = 12;
  localparam int unsigned CfgW   = 13;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WIDTH     = 2'd0,
    REG_HEIGHT    = 2'd1,
    REG_THRESHOLD = 2'd2
  } cfg_reg_e;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture pixel, issue line store read
    logic compute;  // update window, write line stores, run gradient
    logic sqrt_step;// sum the squares, then one root bit
    logic emit;     // result register filled
    logic pop;      // result register drained
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic interior;  // current pixel has a full window
    logic sqrt_done; // last root bit done
    logic out_full;  // result register holds a result
  } dp_sts_t;
endpackage
`default_nettype wire

// ----- hdl/sdef_ctrl.sv -----
// ----------------------------------------------------------------------------
// sdef_ctrl: sequencing state machine
// Steps one pixel through read and compute, then, for interior pixels, root iteration and result handoff.
// ----------------------------------------------------------------------------
`default_nettype none
module sdef_ctrl
  import sdef_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_fire_i,
  input  wire logic    out_fire_i,
  input  dp_sts_t      sts_i,
  output dp_cmd_t      cmd_o,
  output logic         in_ready_o
);
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CALC = 4'b0010,
    ST_ROOT = 4'b0100,
    ST_HOLD = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.load = in_fire_i;
    cmd_o.pop  = out_fire_i;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_fire_i) state_d = ST_CALC;
      end
      ST_CALC: begin
        cmd_o.compute = 1'b1;
        state_d = sts_i.interior ? ST_ROOT : ST_IDLE;
      end
      ST_ROOT: begin
        cmd_o.sqrt_step = 1'b1;
        if (sts_i.sqrt_done) state_d = ST_HOLD;
      end
      ST_HOLD: begin
        // result register free (or freeing now)
        if (!sts_i.out_full || out_fire_i) begin
          cmd_o.emit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end
endmodule
`default_nettype wire

// ----- hdl/sdef_datapath.sv -----
// ----------------------------------------------------------------------------
// sdef_datapath: counters, line stores, window, gradient and root
// Bit-serial integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module sdef_datapath
  import sdef_pkg::*;
#(
  parameter int unsigned MaxWidth = 4096
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  dp_cmd_t                cmd_i,
  output dp_sts_t                sts_o,
  input  wire logic [PixW-1:0]   pixel_i,
  input  wire logic              frame_start_i,
  input  wire logic [CfgW-1:0]   width_i,
  input  wire logic [CfgW-1:0]   height_i,
  input  wire logic [PixW-1:0]   threshold_i,
  output logic [PixW-1:0]        edge_o,
  output logic [CoordW-1:0]      row_o,
  output logic [CoordW-1:0]      col_o,
  output logic                   out_valid_o
);
  // usable row length never exceeds 4096
  localparam int unsigned Lim   = (MaxWidth < 4096) ? MaxWidth : 4096;
  localparam int unsigned AddrW = $clog2(Lim);

  logic [PixW-1:0] mem_a [Lim];
  logic [PixW-1:0] mem_b [Lim];

  logic [CoordW-1:0] row_q, col_q, r_q, c_q;
  logic [PixW-1:0]   pix_q, top_q, mid_q;
  logic [PixW-1:0]   win_q [6];
  logic [12:0]       w_eff, h_eff;

  always_comb begin
    w_eff = width_i;
    if (w_eff < 13'd3) w_eff = 13'd3;
    if (w_eff > 13'(Lim)) w_eff = 13'(Lim);
    h_eff = height_i;
    if (h_eff < 13'd3) h_eff = 13'd3;
    if (h_eff > 13'd4096) h_eff = 13'd4096;
  end

  // position of the incoming pixel
  logic [12:0] r0, c0, r1;
  logic [CoordW-1:0] r_n, c_n;
  always_comb begin
    r0 = frame_start_i ? '0 : {1'b0, row_q};
    c0 = frame_start_i ? '0 : {1'b0, col_q};
    r1 = r0;
    if (c0 >= w_eff) begin
      c0 = '0;
      r1 = r0 + 13'd1;
    end
    if (r1 >= h_eff) r1 = '0;
    r_n = r1[CoordW-1:0];
    c_n = c0[CoordW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pix_q <= pixel_i;
      r_q   <= r_n;
      c_q   <= c_n;
      top_q <= mem_b[c_n[AddrW-1:0]];
      mid_q <= mem_a[c_n[AddrW-1:0]];
    end
    if (cmd_i.compute) begin
      mem_b[c_q[AddrW-1:0]] <= mid_q;
      mem_a[c_q[AddrW-1:0]] <= pix_q;
    end
  end

  logic [12:0] c_inc, r_inc;
  assign c_inc = {1'b0, c_q} + 13'd1;
  assign r_inc = {1'b0, r_q} + 13'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      for (int i = 0; i < 6; i++) win_q[i] <= '0;
    end else if (cmd_i.compute) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= top_q;
      win_q[4] <= mid_q;
      win_q[5] <= pix_q;
      if (c_inc >= w_eff) begin
        col_q <= '0;
        row_q <= (r_inc >= h_eff) ? '0 : r_inc[CoordW-1:0];
      end else begin
        col_q <= c_inc[CoordW-1:0];
        row_q <= r_q;
      end
    end
  end

  // gradient (11 bit signed range)
  logic signed [11:0] gx, gy;
  logic [10:0] ax, ay;
  logic [21:0] sq;
  always_comb begin
    gx = (12'(win_q[2]) + 12'(win_q[5]) * 12'sd2 + 12'(pix_q))
       - (12'(win_q[0]) + 12'(win_q[3]) * 12'sd2 + 12'(top_q));
    gy = (12'(win_q[0]) + 12'(win_q[1]) * 12'sd2 + 12'(win_q[2]))
       - (12'(top_q) + 12'(mid_q) * 12'sd2 + 12'(pix_q));
    ax = gx[11] ? 11'(-gx) : 11'(gx);
    ay = gy[11] ? 11'(-gy) : 11'(gy);
    sq = 22'(ax) * 22'(ax);
  end

  // squares summed: x^2 at compute, y^2 added at first root step
  logic [22:0] s_q;
  logic [10:0] ay_q;
  logic        sel_q, sumd_q;
  logic [PixW-1:0] root_q;
  logic [3:0]  bit_q;
  logic        interior;
  assign interior = (r_q >= 12'd2) && (c_q >= 12'd2);

  logic [PixW-1:0] trial;
  logic [15:0]     tsq;
  assign trial = root_q | (8'd1 << bit_q[2:0]);
  assign tsq   = 16'(trial) * 16'(trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q    <= '0;
      ay_q   <= '0;
      sel_q  <= 1'b0;
      root_q <= '0;
      bit_q  <= '0;
      sumd_q <= 1'b0;
    end else if (cmd_i.compute) begin
      s_q    <= 23'(sq);
      ay_q   <= ay;
      sel_q  <= (ay >= ax) && (gy != 0);
      root_q <= '0;
      bit_q  <= 4'd7;
      sumd_q <= 1'b0;
    end else if (cmd_i.sqrt_step) begin
      if (!sumd_q) begin
        s_q    <= s_q + 23'(22'(ay_q) * 22'(ay_q));
        sumd_q <= 1'b1;
      end else begin
        if (s_q >= 23'd65536) root_q <= 8'd255;
        else if (23'(tsq) <= s_q) root_q <= trial;
        bit_q <= bit_q - 4'd1;
      end
    end
  end

  assign sts_o.interior  = interior;
  assign sts_o.sqrt_done = sumd_q && (bit_q == 4'd0);
  assign sts_o.out_full  = out_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (cmd_i.emit) out_valid_o <= 1'b1;
    else if (cmd_i.pop)  out_valid_o <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      edge_o <= (sel_q && root_q >= threshold_i) ? root_q : '0;
      row_o  <= r_q - 12'd1;
      col_o  <= c_q - 12'd1;
    end
  end
endmodule
`default_nettype wire

// ----- hdl/sobel_directional_edge_filter.sv -----
// ----------------------------------------------------------------------------
// sobel_directional_edge_filter: Sobel magnitude kept near vertical gradient
// Top level: config registers, controller and datapath.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one per transfer; frame_start (tuser) resets
// the position. Each interior pixel yields one result: the saturated Sobel
// magnitude when |gy| >= |gx| and gy != 0 and it reaches the threshold, else
// 0, with its row and column. Border pixels give no result. A pixel that
// gives no result is read and passes the gradient step; one that does also
// sums the squares, runs eight root bits in the bit-serial square root and
// is handed off. The result register lets the next pixel enter while a
// result waits. Line store contents start undefined and need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none
module sobel_directional_edge_filter
  import sdef_pkg::*;
#(
  parameter int unsigned MaxWidth = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] pixel_value
  input  wire logic        s_axis_tuser,   // [0] frame_start
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [7:0] edge_value, [19:8] out_row,
                                           // [31:20] out_col
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_addr_i,
  input  wire logic [12:0] cfg_wdata_i
);
  logic [CfgW-1:0] width_q, height_q;
  logic [PixW-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd640;
      height_q <= 13'd480;
      thr_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_WIDTH:     width_q  <= cfg_wdata_i;
        REG_HEIGHT:    height_q <= cfg_wdata_i;
        REG_THRESHOLD: thr_q    <= cfg_wdata_i[PixW-1:0];
        default: ;
      endcase
    end
  end

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic in_fire, out_fire;
  logic [PixW-1:0]   edge_v;
  logic [CoordW-1:0] row_v, col_v;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  sdef_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i (in_fire),
    .out_fire_i(out_fire),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .in_ready_o(s_axis_tready)
  );

  sdef_datapath #(.MaxWidth(MaxWidth)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i        (cmd),
    .sts_o        (sts),
    .pixel_i      (s_axis_tdata),
    .frame_start_i(s_axis_tuser),
    .width_i      (width_q),
    .height_i     (height_q),
    .threshold_i  (thr_q),
    .edge_o       (edge_v),
    .row_o        (row_v),
    .col_o        (col_v),
    .out_valid_o  (m_axis_tvalid)
  );

  assign m_axis_tdata = {col_v, row_v, edge_v};
endmodule
`default_nettype wire

// ----- sim/tb_sobel_directional_edge_filter.sv -----
// ----------------------------------------------------------------------------
// tb_sobel_directional_edge_filter: self-checking bench for the Sobel filter
// Streams small frames, predicts each interior result with a behavioral
// copy of the line stores and window, and checks results in order.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_sobel_directional_edge_filter
  import sdef_pkg::*;
();

  typedef struct packed {
    logic [11:0] col;
    logic [11:0] row;
    logic [7:0]  edge_val;
  } edge_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_addr_i = '0;
  logic [12:0] cfg_wdata_i = '0;

  always #4 clk_i = ~clk_i;

  sobel_directional_edge_filter dut (.*);

  // predictor state
  int unsigned img_w, img_h, thresh;
  logic [7:0]  row_prev[4096];  // previous row
  logic [7:0]  row_prev2[4096]; // row before it
  logic [7:0]  win[6];
  int unsigned cur_row, cur_col;
  edge_res_t   pending_edges[$];
  int unsigned errors = 0;
  int unsigned sent = 0;        // pixels transferred so far
  int          dir_exp = -1;    // fixed edge value expected, -1: none

  // receiver control
  bit rx_hold = 1'b0;
  bit rx_calm = 1'b0;
  bit tx_calm = 1'b0;

  function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned isqrt_sat(int unsigned s);
    int unsigned r = 0;
    int unsigned t;
    if (s >= 65536) return 255;
    for (int b = 7; b >= 0; b--) begin
      t = r | (1 << b);
      if (t * t <= s) r = t;
    end
    return r;
  endfunction

  // advance predictor by one accepted pixel
  task automatic predict_pixel(input logic [7:0] pix, input logic fs);
    int unsigned w, h, r, c, m;
    int gx, gy, ax, ay;
    logic [7:0] top, mid;
    edge_res_t res;
    w = clamp(img_w, 3, 4096);
    h = clamp(img_h, 3, 4096);
    if (fs) begin
      cur_row = 0;
      cur_col = 0;
    end
    if (cur_col >= w) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= h) cur_row = 0;
    r = cur_row;
    c = cur_col;
    top = row_prev2[c];
    mid = row_prev[c];
    if (r >= 2 && c >= 2) begin
      gx = (int'(win[2]) + 2 * int'(win[5]) + int'(pix))
         - (int'(win[0]) + 2 * int'(win[3]) + int'(top));
      gy = (int'(win[0]) + 2 * int'(win[1]) + int'(win[2]))
         - (int'(top) + 2 * int'(mid) + int'(pix));
      ax = gx < 0 ? -gx : gx;
      ay = gy < 0 ? -gy : gy;
      m = isqrt_sat(ax * ax + ay * ay);
      res.edge_val = (ay >= ax && gy != 0 && m >= thresh) ? m[7:0] : 8'd0;
      res.row = 12'(r - 1);
      res.col = 12'(c - 1);
      pending_edges.push_back(res);
    end
    win[0] = win[3]; win[1] = win[4]; win[2] = win[5];
    win[3] = top;    win[4] = mid;    win[5] = pix;
    row_prev2[c] = mid;
    row_prev[c] = pix;
    cur_col = c + 1;
    if (cur_col >= w) begin
      cur_col = 0;
      cur_row = r + 1;
      if (cur_row >= h) cur_row = 0;
    end
  endtask

  task automatic write_reg(input cfg_reg_e idx, input int unsigned val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= 13'(val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_WIDTH:     img_w = val;
      REG_HEIGHT:    img_h = val;
      REG_THRESHOLD: thresh = val & 8'hFF;
      default: ;
    endcase
  endtask

  // offer one pixel, wait for its transfer; inputs move on falling edges
  task automatic send_pixel(input logic [7:0] pix, input logic fs);
    while (!tx_calm && $urandom_range(99) < 22) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= pix;
    s_axis_tuser <= fs;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_pixel(pix, fs);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending_edges.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i); // covers a border pixel still in flight
  endtask

  // one frame: mode 0 random, 1 flat, 2 horizontal stripes, 3 extremes,
  // 4 bright left column
  task automatic send_frame(input int unsigned mode);
    int unsigned w, h;
    logic [7:0] p;
    w = clamp(img_w, 3, 4096);
    h = clamp(img_h, 3, 4096);
    for (int unsigned r = 0; r < h; r++)
      for (int unsigned c = 0; c < w; c++) begin
        case (mode)
          1: p = 8'd77;
          2: p = (r % 2) ? 8'hFF : 8'h00;
          3: p = $urandom_range(1) ? 8'hFF : 8'h00;
          4: p = (c == 0) ? 8'hFF : 8'h00;
          default: p = 8'($urandom);
        endcase
        send_pixel(p, r == 0 && c == 0);
      end
  endtask

  // receiver: random stalls, always ready when calm, or a long hold-off on request
  always @(negedge clk_i) begin
    if (rx_hold) m_axis_tready <= 1'b0;
    else if (rx_calm) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(99) >= 22);
  end

  // checker
  always @(posedge clk_i) begin
    edge_res_t got, exp_res;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (dir_exp >= 0 && got.edge_val !== 8'(dir_exp)) begin
        $error("edge_value exp %0d got %0d", dir_exp, got.edge_val);
        errors++;
      end
      if (pending_edges.size() == 0) begin
        $error("unexpected result %h", m_axis_tdata);
        errors++;
      end else begin
        exp_res = pending_edges.pop_front();
        if (got.edge_val !== exp_res.edge_val) begin
          $error("edge_value exp %0d got %0d", exp_res.edge_val, got.edge_val);
          errors++;
        end
        if (got.row !== exp_res.row) begin
          $error("out_row exp %0d got %0d", exp_res.row, got.row);
          errors++;
        end
        if (got.col !== exp_res.col) begin
          $error("out_col exp %0d got %0d", exp_res.col, got.col);
          errors++;
        end
      end
    end
  end

  // directed rows: register settings, frame content, fixed edge value
  typedef struct {
    int unsigned w, h, th, mode;
    int          exp_edge;
  } dir_row_t;

  dir_row_t dir_tbl[] = '{
    '{3, 3, 0, 1, 0},       // smallest frame, flat: no gradient, 0
    '{3, 3, 0, 2, 0},       // horizontal stripes: both sums cancel, 0
    '{3, 3, 0, 4, 255},     // bright left column: pure gy, saturates
    '{4, 3, 255, 3, -1},    // top threshold
    '{5, 4, 0, 0, -1},
    '{0, 2, 10, 0, -1},     // sizes below minimum clamp to 3
    '{8191, 3, 0, 1, -1}    // width beyond maximum clamps to 4096
  };

  initial begin
    img_w = 640; img_h = 480; thresh = 0;
    cur_row = 0; cur_col = 0;
    foreach (win[i]) win[i] = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // after reset: flat rows of default width give 0 edges once interior
    dir_exp = 0;
    for (int i = 0; i < 2 * 640 + 8; i++) send_pixel(8'd9, i == 0);
    drain();
    dir_exp = -1;

    foreach (dir_tbl[i]) begin
      write_reg(REG_WIDTH, dir_tbl[i].w);
      write_reg(REG_HEIGHT, dir_tbl[i].h);
      write_reg(REG_THRESHOLD, dir_tbl[i].th);
      dir_exp = dir_tbl[i].exp_edge;
      if (dir_tbl[i].w > 4096) begin
        for (int k = 0; k < 3; k++) send_pixel(8'($urandom), k == 0);
      end else send_frame(dir_tbl[i].mode);
      drain();
      dir_exp = -1;
    end
    // leftover from the wide frame: drain it; the next frame restarts with frame_start
    if (pending_edges.size() != 0) drain();

    // long receiver hold-off while pixels keep coming
    write_reg(REG_WIDTH, 6);
    write_reg(REG_HEIGHT, 5);
    write_reg(REG_THRESHOLD, 0);
    rx_hold = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        rx_hold = 1'b0;
      end
      send_frame(0);
    join
    drain();

    // random part: small frames, changing sizes and thresholds
    while (sent < 1750) begin
      int unsigned w, h;
      w = $urandom_range(3, 12);
      h = $urandom_range(3, 8);
      if ($urandom_range(9) == 0) w = $urandom_range(0, 2);
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
      write_reg(REG_THRESHOLD, $urandom_range(3) == 0 ? $urandom_range(255)
                                                      : $urandom_range(40));
      rx_calm = ($urandom_range(7) == 0);
      tx_calm = rx_calm;
      repeat ($urandom_range(1, 3)) send_frame($urandom_range(4) == 0 ? 3 : 0);
      // continuing without frame_start across a wrap, then a partial frame
      repeat ($urandom_range(0, 20)) send_pixel(8'($urandom), 1'b0);
      drain(); // sender pauses until every result is in
    end

    s_axis_tvalid <= 1'b0;
    drain();
    if (errors == 0 && pending_edges.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end
endmodule
`default_nettype wire
